[rtl/mbbc_pkg.sv]
// mbbc_pkg: shared types and constants for the monochrome bitmap blit block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mbbc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_INVERT        = 3'd4;

    localparam logic [9:0] ROW_MAX = 10'd1023;

    typedef struct packed {
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [9:0] bitmap_width;
        logic [9:0] bitmap_height;
        logic       invert;
    } cfg_t;

    // One visible run of pixels from a byte, as queued for the back end
    typedef struct packed {
        logic [7:0] base_x;
        logic [7:0] y;
        logic [7:0] bits;     // already inverted if required, bit 7 leftmost
        logic [3:0] count;    // 1..8 pixels
    } run_t;

endpackage

[rtl/mbbc_front.sv]
// mbbc_front: accepts bitmap bytes, tracks column and row, clips each byte
// to the visible area and produces a pixel run. Depends on mbbc_pkg.
`timescale 1ns / 1ps

module mbbc_front
    import mbbc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 160
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] bitmap_byte,
    input  logic       start_image,
    output logic       push,
    output run_t       run
);

    localparam logic [7:0] SW8 = 8'(SCREEN_WIDTH);
    localparam logic [7:0] SH8 = 8'(SCREEN_HEIGHT);

    logic [6:0] byte_column_reg, byte_column_next;
    logic [9:0] row_count_reg, row_count_next;

    logic [6:0] bc_eff;
    logic [9:0] row_eff;
    logic [7:0] per_row;
    logic       origin_ok;
    logic [7:0] room_x, room_y;
    logic [9:0] vis_w, vis_h;
    logic [9:0] col0;
    logic [9:0] remain;
    logic [6:0] nb;
    logic       wrap;
    logic       emit;

    always_comb
    begin
        bc_eff    = start_image ? 7'd0 : byte_column_reg;
        row_eff   = start_image ? 10'd0 : row_count_reg;
        per_row   = 8'((11'(cfg.bitmap_width) + 11'd7) >> 3);
        origin_ok = (cfg.origin_x < SW8) && (cfg.origin_y < SH8);
        room_x    = SW8 - cfg.origin_x;
        room_y    = SH8 - cfg.origin_y;
        vis_w     = (cfg.bitmap_width < {2'b00, room_x}) ? cfg.bitmap_width
                                                          : {2'b00, room_x};
        vis_h     = (cfg.bitmap_height < {2'b00, room_y}) ? cfg.bitmap_height
                                                           : {2'b00, room_y};
        col0      = {bc_eff, 3'b000};
        remain    = vis_w - col0;
        emit      = origin_ok && (row_eff < vis_h) && (col0 < vis_w);

        push      = accept && emit;
        run.base_x = cfg.origin_x + col0[7:0];
        run.y      = cfg.origin_y + row_eff[7:0];
        run.bits   = bitmap_byte ^ {8{cfg.invert}};
        run.count  = (remain >= 10'd8) ? 4'd8 : remain[3:0];

        // byte column wraps at bytes per row, or on 7-bit overflow
        nb   = bc_eff + 7'd1;
        wrap = (nb == 7'd0) || ({1'b0, nb} >= per_row);
        byte_column_next = byte_column_reg;
        row_count_next   = row_count_reg;
        if (accept)
        begin
            byte_column_next = wrap ? 7'd0 : nb;
            row_count_next   = row_eff;
            if (wrap && (row_eff != ROW_MAX))
            begin
                row_count_next = row_eff + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= 7'd0;
            row_count_reg   <= 10'd0;
        end
        else
        begin
            byte_column_reg <= byte_column_next;
            row_count_reg   <= row_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (run.count != 4'd0) && (run.count <= 4'd8))
        else $error("front: pushed run with bad pixel count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(byte_column_reg) && $stable(row_count_reg))
        else $error("front: counters moved without an item");

endmodule

[rtl/mbbc_queue.sv]
// mbbc_queue: small register FIFO of pixel runs between front and back end.
// Depends on mbbc_pkg for run_t.
`timescale 1ns / 1ps

module mbbc_queue
    import mbbc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output run_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    run_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == FULL_CNT);
        head_valid = (count_reg != '0);
        head       = mem_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue: push while full");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
        else $error("queue: pop while empty");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue: fill count out of range");

endmodule

[rtl/mbbc_back.sv]
// mbbc_back: walks the head pixel run one pixel a cycle, unless the output is
// stalled by out_ready, into the output register. Depends on mbbc_pkg for run_t.
`timescale 1ns / 1ps

module mbbc_back
    import mbbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  run_t       head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_x,
    output logic [7:0] pixel_y,
    output logic       pixel_on,
    output logic       last_of_byte
);

    logic [2:0] z_reg, z_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_x_reg;
    logic [7:0] pixel_y_reg;
    logic       pixel_on_reg;
    logic       last_reg;
    logic       load;
    logic       last;

    always_comb
    begin
        load = head_valid && (!out_valid_reg || out_ready);
        last = ({1'b0, z_reg} == (head.count - 4'd1));
        pop  = load && last;
        z_next = z_reg;
        if (load)
        begin
            z_next = last ? 3'd0 : z_reg + 3'd1;
        end
        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            z_reg         <= z_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_x_reg  <= head.base_x + {5'd0, z_reg};
            pixel_y_reg  <= head.y;
            pixel_on_reg <= head.bits[3'd7 - z_reg];
            last_reg     <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_on     = pixel_on_reg;
    assign last_of_byte = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, z_reg} < head.count))
        else $error("back: pixel index past end of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (z_reg == 3'd0))
        else $error("back: pixel index left over with empty queue");

endmodule

[rtl/mono_bitmap_blit_clip.sv]
// mono_bitmap_blit_clip: top level, configuration registers and wiring of
// front end, run queue and pixel back end. Depends on mbbc_pkg, mbbc_front,
// mbbc_queue and mbbc_back.
//
//  channel   dir  handshake             payload
//  cfg       in   cfg_wr_en             cfg_index, cfg_data
//  in        in   in_valid / in_ready   bitmap_byte, start_image
//  out       out  out_valid / out_ready pixel_x, pixel_y, pixel_on, last_of_byte
//
// A byte yields 0..8 pixels, one per cycle from the back end while out_ready
// is not held low. A two-run queue lets bytes keep arriving while earlier
// pixels drain. in_ready drops only while the queue is full; bytes with
// nothing visible still pass through the front end, which queues no run for
// them. Reset clears counters, configuration and queue; no clearing pass.
`timescale 1ns / 1ps

module mono_bitmap_blit_clip
    import mbbc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 160
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] bitmap_byte,
    input  logic       start_image,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_x,
    output logic [7:0] pixel_y,
    output logic       pixel_on,
    output logic       last_of_byte
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic push;
    run_t run;
    logic full;
    logic pop;
    logic head_valid;
    run_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[7:0];
                REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[7:0];
                REG_BITMAP_WIDTH:  cfg_next.bitmap_width  = cfg_data;
                REG_BITMAP_HEIGHT: cfg_next.bitmap_height = cfg_data;
                REG_INVERT:        cfg_next.invert        = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    mbbc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .bitmap_byte (bitmap_byte),
        .start_image (start_image),
        .push        (push),
        .run         (run)
    );

    mbbc_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (run),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mbbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_on     (pixel_on),
        .last_of_byte (last_of_byte)
    );

    assert property (@(posedge clk) disable iff (!rst_n) push |-> accept)
        else $error("top: run queued without an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_on) && $stable(last_of_byte))
        else $error("top: pixel changed while waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && (cfg_index == REG_INVERT)) |=> (cfg_reg.invert == $past(cfg_data[0])))
        else $error("top: invert register not written");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for mono_bitmap_blit_clip.
// Drives bitmap bytes and register writes, predicts every clipped pixel and
// checks the output stream in order. Depends on mbbc_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top
    import mbbc_pkg::*;
();

    localparam int SCREEN_W    = 160;
    localparam int SCREEN_H    = 160;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       on;
        logic       last;
    } pixel_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [2:0] cfg_index   = REG_ORIGIN_X;
    logic [9:0] cfg_data    = '0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] bitmap_byte = '0;
    logic       start_image = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
    logic       last_of_byte;

    // Shadow of the block's registers and counters
    logic [7:0] cur_ox  = '0;
    logic [7:0] cur_oy  = '0;
    logic [9:0] cur_w   = '0;
    logic [9:0] cur_h   = '0;
    logic       cur_inv = 1'b0;
    logic [6:0] col_idx = '0;
    logic [9:0] row_idx = '0;

    pixel_t pixel_q[$];
    int     mismatches = 0;
    int     hold_len   = 0;
    int     stall_left = 0;
    int     cycles     = 0;
    bit     idle_on    = 1'b1;

    mono_bitmap_blit_clip #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bitmap_byte  (bitmap_byte),
        .start_image  (start_image),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_on     (pixel_on),
        .last_of_byte (last_of_byte)
    );

    always #6 clk = ~clk;

    // Expected pixels for one accepted byte, then advance the counters
    function automatic void blit_byte(input logic [7:0] bits, input logic start);
        int     per_row;
        int     vis_w;
        int     vis_h;
        int     col;
        pixel_t px;
        per_row = (int'(cur_w) + 7) >> 3;
        if (start)
        begin
            col_idx = '0;
            row_idx = '0;
        end
        if (int'(cur_ox) < SCREEN_W && int'(cur_oy) < SCREEN_H)
        begin
            vis_w = SCREEN_W - int'(cur_ox);
            if (int'(cur_w) < vis_w)
                vis_w = int'(cur_w);
            vis_h = SCREEN_H - int'(cur_oy);
            if (int'(cur_h) < vis_h)
                vis_h = int'(cur_h);
            if (int'(row_idx) < vis_h)
            begin
                for (int z = 0; z < 8; z++)
                begin
                    col = int'(col_idx) * 8 + z;
                    if (col < vis_w)
                    begin
                        px.x    = 8'(int'(cur_ox) + col);
                        px.y    = 8'(int'(cur_oy) + int'(row_idx));
                        px.on   = bits[7 - z] ^ cur_inv;
                        px.last = (z == 7) || (col + 1 >= vis_w);
                        pixel_q.push_back(px);
                    end
                end
            end
        end
        col_idx = col_idx + 7'd1;
        if (col_idx == 7'd0 || int'(col_idx) >= per_row)
        begin
            col_idx = '0;
            if (row_idx != ROW_MAX)
                row_idx = row_idx + 10'd1;
        end
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_ORIGIN_X:      cur_ox  = val[7:0];
            REG_ORIGIN_Y:      cur_oy  = val[7:0];
            REG_BITMAP_WIDTH:  cur_w   = val;
            REG_BITMAP_HEIGHT: cur_h   = val;
            REG_INVERT:        cur_inv = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] ox, input logic [7:0] oy,
                             input logic [9:0] w, input logic [9:0] h, input logic inv);
        write_reg(REG_ORIGIN_X, {2'b00, ox});
        write_reg(REG_ORIGIN_Y, {2'b00, oy});
        write_reg(REG_BITMAP_WIDTH, w);
        write_reg(REG_BITMAP_HEIGHT, h);
        write_reg(REG_INVERT, {9'd0, inv});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] bits, input logic start);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        bitmap_byte <= bits;
        start_image <= start;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blit_byte(bits, start);
    endtask

    // Stop sending and wait for every expected pixel to be taken
    task automatic drain();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_origin();
        case ($urandom_range(0, 7))
            0: return 8'($urandom_range(150, 175));
            1: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            2: return 8'($urandom_range(156, 159));
            default: return 8'($urandom_range(0, 140));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Whole images with random content, plus truncated, overlong and restarted ones
    task automatic random_images(input int n_items);
        int sent;
        int w;
        int h;
        int len;
        logic st;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(41, 1023);
                default: w = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = $urandom_range(13, 1023);
                default: h = $urandom_range(1, 12);
            endcase
            configure(pick_origin(), pick_origin(), w[9:0], h[9:0], 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
            begin
                len = ((w + 7) / 8) * h;
                if (len > 48)
                    len = 48;
                if (len == 0)
                    len = $urandom_range(1, 6);
                case ($urandom_range(0, 5))
                    0: len = $urandom_range(1, len);
                    1: len = len + $urandom_range(1, 8);
                    default: ;
                endcase
                for (int i = 0; i < len; i++)
                begin
                    if (i == 0)
                        st = ($urandom_range(0, 7) != 0);
                    else
                        st = ($urandom_range(0, 19) == 0);
                    send_byte(pick_byte(), st);
                    sent++;
                end
            end
            drain();
        end
    endtask

    task automatic test_directed();
        configure(10, 20, 20, 3, 0);           // 3 bytes per row, last one 4 px
        send_byte(8'hFF, 1);
        send_byte(8'h00, 0);
        send_byte(8'hA5, 0);
        send_byte(8'h80, 0);
        send_byte(8'h01, 0);
        send_byte(8'h81, 1);                   // restart mid-image
        send_byte(8'h0F, 0);
        send_byte(8'hF0, 0);
        send_byte(8'hC3, 0);
        send_byte(8'h5A, 0);
        send_byte(8'h3C, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);                   // still in the last bitmap row
        drain();
        configure(0, 0, 8, 2, 1);
        send_byte(8'h00, 1);
        send_byte(8'hFF, 0);
        drain();
        configure(159, 159, 16, 4, 0);         // one visible pixel at the corner
        send_byte(8'hAA, 1);
        send_byte(8'h55, 0);
        send_byte(8'hFF, 0);
        drain();
        configure(160, 0, 8, 8, 0);            // origin off screen
        send_byte(8'hFF, 1);
        drain();
        configure(0, 255, 8, 8, 1);
        send_byte(8'h00, 1);
        drain();
        configure(0, 0, 0, 5, 1);              // zero width
        send_byte(8'hFF, 1);
        send_byte(8'hFF, 0);
        drain();
        configure(5, 5, 8, 0, 0);              // zero height
        send_byte(8'hFF, 1);
        drain();
        configure(0, 0, 1023, 1023, 1);
        send_byte(8'h5A, 1);
        send_byte(8'h3C, 0);
        drain();
    endtask

    // Narrowing the width past the current byte forces a wrap to the next row
    task automatic test_mid_image_change();
        configure(40, 40, 32, 6, 0);
        send_byte(8'hFF, 1);
        send_byte(8'h96, 0);
        send_byte(8'h69, 0);
        drain();
        write_reg(REG_BITMAP_WIDTH, 10'd16);
        cfg_wr_en <= 1'b0;
        send_byte(8'hFF, 0);
        send_byte(8'hE7, 0);
        send_byte(8'h18, 0);
        drain();
        write_reg(REG_BITMAP_HEIGHT, 10'd2);
        write_reg(REG_INVERT, 10'd1);
        cfg_wr_en <= 1'b0;
        send_byte(8'hF0, 0);
        send_byte(8'h0F, 0);
        send_byte(8'hAA, 0);
        drain();
    endtask

    // 128 bytes per row: the byte column wraps through zero
    task automatic test_wide_rows();
        configure(150, 2, 1023, 2, 0);
        for (int i = 0; i < 132; i++)
            send_byte(pick_byte(), i == 0);
        drain();
    endtask

    task automatic test_backpressure();
        configure(0, 0, 64, 4, 0);
        hold_len = 300;
        for (int i = 0; i < 32; i++)
            send_byte(pick_byte(), i == 0);
        drain();
    endtask

    task automatic test_random_traffic();
        random_images(100);
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        random_images(50);
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixel_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: x=%0d y=%0d on=%0b last=%0b",
                         pixel_x, pixel_y, pixel_on, last_of_byte);
        end
        else
        begin
            want = pixel_q.pop_front();
            if (pixel_x !== want.x || pixel_y !== want.y ||
                pixel_on !== want.on || last_of_byte !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d,%0d on=%0b last=%0b got %0d,%0d on=%0b last=%0b",
                             want.x, want.y, want.on, want.last,
                             pixel_x, pixel_y, pixel_on, last_of_byte);
            end
        end
    endtask

    // Output side: check each pixel taken, then choose next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_pixel();
            if (hold_len > 0)
            begin
                stall_left = hold_len;
                hold_len   = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("mono_bitmap_blit_clip test failed");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mid_image_change();
        test_wide_rows();
        test_backpressure();
        test_random_traffic();
        test_full_rate();
        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("mono_bitmap_blit_clip test passed");
        else
            $display("mono_bitmap_blit_clip test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/mbbc_pkg.sv
rtl/mbbc_front.sv
rtl/mbbc_queue.sv
rtl/mbbc_back.sv
rtl/mono_bitmap_blit_clip.sv
tb/tb_top.sv
